[sv/hlcd_pkg.sv]
// shared types, constants and the crc byte update for the header/length/crc16 deframer
// no dependencies; imported by the top, datapath and controller modules of the block
package hlcd_pkg;

  localparam int          STORE_DEPTH_DEF = 8192;
  localparam logic [15:0] HEADER_RESET    = 16'h0566;
  localparam int          MIN_FRAME       = 8;
  localparam int          FRAME_OVERHEAD  = 6;
  localparam int          PAYLOAD_OFFSET  = 4;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

  // register index decoded from paddr
  localparam logic REG_HEADER = 1'b0;
  localparam logic REG_RUN    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_FRAME = 2'd2,
    ST_DISABLED = 2'd3
  } hlcd_status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_POP_RD,
    S_POP_TAKE,
    S_HUNT,
    S_HDR_A,
    S_HDR_B,
    S_HDR_C,
    S_LEN_A,
    S_LEN_B,
    S_LEN_C,
    S_LEN_D,
    S_CRC_A,
    S_CRC_B,
    S_TRL_A,
    S_TRL_B,
    S_TRL_C,
    S_DONE
  } hlcd_state_t;

  typedef struct packed {
    logic         start;       // new request: load status, clear popped byte
    hlcd_status_t st_val;
    logic         clear;       // empty the store, drop a held frame
    logic         push;
    logic         addr_pop;    // read address from pop offset instead of scan offset
    logic         off_load;
    logic         off_two;
    logic         off_inc;
    logic         cap_byte0;
    logic         len_load;
    logic         crc_init;
    logic         crc_upd;
    logic         drop_one;
    logic         drop_frame;
    logic         count_rej;
    logic         set_pending;
    logic         pop_take;
    logic         out_load;
  } hlcd_cmd_t;

  typedef struct packed {
    logic pending;
    logic full;
    logic fill_lt2;
    logic fill_lt8;
    logic hdr_match;
    logic too_long;
    logic short_fill;
    logic crc_last;
    logic crc_ok;
    logic dlen_zero;
    logic out_valid;
  } hlcd_stat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[sv/hlcd_in_if.sv]
// request channel of the deframer: func and rx_byte with valid/ready
// no dependencies
interface hlcd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

[sv/hlcd_out_if.sv]
// result channel of the deframer: status, frame info and popped byte with valid/ready
// no dependencies
interface hlcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        frame_ready;
  logic [12:0] payload_length;
  logic [7:0]  payload_byte;
  logic        payload_last;
  logic [15:0] crc_error_count;

  modport source (output valid, output status, output frame_ready, output payload_length,
                  output payload_byte, output payload_last, output crc_error_count,
                  input ready);
  modport sink   (input valid, input status, input frame_ready, input payload_length,
                  input payload_byte, input payload_last, input crc_error_count,
                  output ready);
endinterface

[sv/header_length_crc16_deframer_unit.sv]
// Frame deframer: pushed bytes go into a ring store and are searched for frames of
// 16-bit header (high byte first), 16-bit little-endian payload length, payload and a
// Modbus CRC16 (low byte first). A checked frame's payload is popped one byte per request.
// One request is handled at a time. After a push or a pop the block hunts for the next frame:
// it skips bytes one at a time while searching for the header, reads the length, runs the CRC
// check over the header, length and payload bytes and then reads the received CRC, every byte
// passing through the single read port of the store; a rejected start restarts the hunt. No
// clearing pass is needed after reset. Configuration (header at 0x0, run at 0x4) is to be
// written only while idle; the block itself does not enforce this.
module header_length_crc16_deframer_unit import hlcd_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  localparam int AW = $clog2(STORE_DEPTH)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  hlcd_in_if.sink     in_ch,
  hlcd_out_if.source  out_ch
);

  logic [15:0]   sync_word;
  logic          run_enable;
  logic          cfg_wr, cfg_clear;
  hlcd_cmd_t     cmd;
  hlcd_stat_t    stat;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign cfg_clear = cfg_wr && (paddr[2] == REG_RUN) && !pwdata[0];
  assign prdata    = (paddr[2] == REG_RUN) ? {31'd0, run_enable} : {16'd0, sync_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word  <= HEADER_RESET;
      run_enable <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_HEADER: sync_word  <= pwdata[15:0];
        REG_RUN:    run_enable <= pwdata[0];
        default:    ;
      endcase
    end
  end

  hlcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .run      (run_enable),
    .in_valid (in_ch.valid),
    .func     (in_ch.func),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hlcd_dp #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .sync_word       (sync_word),
    .cfg_clear       (cfg_clear),
    .rx_byte         (in_ch.rx_byte),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .status          (out_ch.status),
    .frame_ready     (out_ch.frame_ready),
    .payload_length  (out_ch.payload_length),
    .payload_byte    (out_ch.payload_byte),
    .payload_last    (out_ch.payload_last),
    .crc_error_count (out_ch.crc_error_count)
  );

  hlcd_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[sv/hlcd_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
module hlcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/hlcd_dp.sv]
// datapath of the deframer: ring pointers, fill count, crc, frame registers, result register
// depends on hlcd_pkg; drives the byte store ram ports
module hlcd_dp import hlcd_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  localparam int AW = $clog2(STORE_DEPTH),
  localparam int FW = AW + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  hlcd_cmd_t     cmd,
  output hlcd_stat_t    stat,
  input  logic [15:0]   sync_word,
  input  logic          cfg_clear,
  input  logic [7:0]    rx_byte,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  output logic [AW-1:0] ram_raddr,
  input  logic [7:0]    ram_rdata,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    status,
  output logic          frame_ready,
  output logic [12:0]   payload_length,
  output logic [7:0]    payload_byte,
  output logic          payload_last,
  output logic [15:0]   crc_error_count
);

  localparam logic [16:0] DEPTH_L = 17'(STORE_DEPTH);

  logic [AW-1:0] wp, scan;
  logic [FW-1:0] fill;
  logic          pending;
  logic [15:0]   left, dlen, crc, rej;
  logic [16:0]   popoff, off;
  logic [7:0]    byte0, pbyte;
  logic          plast;
  hlcd_status_t  st;

  logic [16:0] flen, fill17, drop_n, rd_off;
  logic        release_frame, do_drop;

  // base plus offset modulo store depth, offset known not to exceed the depth
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base, input logic [16:0] n);
    logic [17:0] s;
    s = 18'(base) + 18'(n);
    if (s >= 18'(STORE_DEPTH)) begin
      s = s - 18'(STORE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign flen   = 17'(dlen) + 17'(FRAME_OVERHEAD);
  assign fill17 = 17'(fill);
  assign rd_off = cmd.addr_pop ? popoff : off;

  assign release_frame = cmd.pop_take && (left == 16'd1);
  assign do_drop       = cmd.drop_one || cmd.drop_frame || release_frame;
  assign drop_n        = cmd.drop_one ? 17'd1 : flen;

  assign ram_we    = cmd.push;
  assign ram_waddr = wp;
  assign ram_wdata = rx_byte;
  assign ram_raddr = wrap_add(scan, rd_off);

  always_comb begin
    stat.pending    = pending;
    stat.full       = fill17 >= DEPTH_L;
    stat.fill_lt2   = fill < FW'(2);
    stat.fill_lt8   = fill < FW'(MIN_FRAME);
    stat.hdr_match  = {byte0, ram_rdata} == sync_word;
    stat.too_long   = flen > DEPTH_L;
    stat.short_fill = fill17 < flen;
    stat.crc_last   = off == (flen - 17'd3);
    stat.crc_ok     = {ram_rdata, byte0} == crc;
    stat.dlen_zero  = dlen == 16'd0;
    stat.out_valid  = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      scan      <= '0;
      fill      <= '0;
      pending   <= 1'b0;
      left      <= '0;
      rej       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear || cfg_clear) begin
        wp      <= '0;
        scan    <= '0;
        fill    <= '0;
        pending <= 1'b0;
        left    <= '0;
      end else begin
        if (cmd.push) begin
          wp   <= (wp == AW'(STORE_DEPTH - 1)) ? '0 : wp + AW'(1);
          fill <= fill + FW'(1);
        end
        if (do_drop) begin
          scan <= wrap_add(scan, drop_n);
          fill <= fill - FW'(drop_n);
        end
        if (cmd.set_pending) begin
          pending <= 1'b1;
          left    <= dlen;
        end
        if (cmd.pop_take) begin
          left <= left - 16'd1;
          if (release_frame) begin
            pending <= 1'b0;
          end
        end
      end
      if (cmd.count_rej && rej != COUNT_MAX) begin
        rej <= rej + 16'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.off_load) begin
      off <= cmd.off_two ? 17'd2 : 17'd0;
    end else if (cmd.off_inc) begin
      off <= off + 17'd1;
    end
    if (cmd.set_pending) begin
      popoff <= 17'(PAYLOAD_OFFSET);
    end else if (cmd.pop_take) begin
      popoff <= popoff + 17'd1;
    end
    if (cmd.cap_byte0) begin
      byte0 <= ram_rdata;
    end
    if (cmd.len_load) begin
      dlen <= {ram_rdata, byte0};
    end
    if (cmd.crc_init) begin
      crc <= CRC_INIT;
    end else if (cmd.crc_upd) begin
      crc <= crc_byte(crc, ram_rdata);
    end
    if (cmd.start) begin
      st    <= cmd.st_val;
      pbyte <= '0;
      plast <= 1'b0;
    end else if (cmd.pop_take) begin
      pbyte <= ram_rdata;
      plast <= left == 16'd1;
    end
    if (cmd.out_load) begin
      status          <= st;
      frame_ready     <= pending;
      payload_length  <= pending ? dlen[12:0] : 13'd0;
      payload_byte    <= pbyte;
      payload_last    <= plast;
      crc_error_count <= rej;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill17 <= DEPTH_L)
    else $error("fill count above store depth");
  a_pending_frame: assert property (@(posedge clk) disable iff (rst)
    pending |-> (dlen != 16'd0 && fill17 >= flen && left != 16'd0))
    else $error("held frame not fully stored");
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (18'(scan) < 18'(STORE_DEPTH)) && (18'(wp) < 18'(STORE_DEPTH)))
    else $error("ring pointer out of range");

endmodule

[sv/hlcd_ctrl.sv]
// controller of the deframer: request decode, frame hunt sequencing, result handoff
// depends on hlcd_pkg; drives the datapath through hlcd_cmd_t
module hlcd_ctrl import hlcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       run,
  input  logic       in_valid,
  input  logic       func,
  output logic       in_ready,
  input  hlcd_stat_t stat,
  output hlcd_cmd_t  cmd
);

  hlcd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = !stat.out_valid;
        if (in_valid && !stat.out_valid) begin
          cmd.start = 1'b1;
          if (!run) begin
            cmd.clear  = 1'b1;
            cmd.st_val = ST_DISABLED;
            state_next = S_DONE;
          end else if (!func) begin
            if (stat.full) begin
              cmd.st_val = ST_FULL;
            end else begin
              cmd.st_val = ST_OK;
              cmd.push   = 1'b1;
            end
            state_next = S_HUNT;
          end else if (stat.pending) begin
            cmd.st_val = ST_OK;
            state_next = S_POP_RD;
          end else begin
            cmd.st_val = ST_NO_FRAME;
            state_next = S_HUNT;
          end
        end
      end
      S_POP_RD: begin
        cmd.addr_pop = 1'b1;
        state_next   = S_POP_TAKE;
      end
      S_POP_TAKE: begin
        cmd.pop_take = 1'b1;
        state_next   = S_HUNT;
      end
      S_HUNT: begin
        if (stat.pending || stat.fill_lt8) begin
          state_next = S_DONE;
        end else begin
          cmd.off_load = 1'b1;
          state_next   = S_HDR_A;
        end
      end
      // header search, one dropped byte per pass
      S_HDR_A: begin
        if (stat.fill_lt2) begin
          state_next = S_DONE;
        end else begin
          cmd.off_inc = 1'b1;
          state_next  = S_HDR_B;
        end
      end
      S_HDR_B: begin
        cmd.cap_byte0 = 1'b1;
        state_next    = S_HDR_C;
      end
      S_HDR_C: begin
        if (!stat.hdr_match) begin
          cmd.drop_one = 1'b1;
          cmd.off_load = 1'b1;
          state_next   = S_HDR_A;
        end else if (stat.fill_lt8) begin
          state_next = S_DONE;
        end else begin
          cmd.off_load = 1'b1;
          cmd.off_two  = 1'b1;
          state_next   = S_LEN_A;
        end
      end
      S_LEN_A: begin
        cmd.off_inc = 1'b1;
        state_next  = S_LEN_B;
      end
      S_LEN_B: begin
        cmd.cap_byte0 = 1'b1;
        state_next    = S_LEN_C;
      end
      S_LEN_C: begin
        cmd.len_load = 1'b1;
        state_next   = S_LEN_D;
      end
      S_LEN_D: begin
        if (stat.too_long) begin
          cmd.drop_one  = 1'b1;
          cmd.count_rej = 1'b1;
          state_next    = S_HUNT;
        end else if (stat.short_fill) begin
          state_next = S_DONE;
        end else begin
          cmd.crc_init = 1'b1;
          cmd.off_load = 1'b1;
          state_next   = S_CRC_A;
        end
      end
      S_CRC_A: begin
        state_next = S_CRC_B;
      end
      S_CRC_B: begin
        cmd.crc_upd = 1'b1;
        cmd.off_inc = 1'b1;
        state_next  = stat.crc_last ? S_TRL_A : S_CRC_A;
      end
      // received crc, low byte first
      S_TRL_A: begin
        cmd.off_inc = 1'b1;
        state_next  = S_TRL_B;
      end
      S_TRL_B: begin
        cmd.cap_byte0 = 1'b1;
        state_next    = S_TRL_C;
      end
      S_TRL_C: begin
        if (!stat.crc_ok) begin
          cmd.drop_one  = 1'b1;
          cmd.count_rej = 1'b1;
          state_next    = S_HUNT;
        end else if (stat.dlen_zero) begin
          cmd.drop_frame = 1'b1;
          state_next     = S_HUNT;
        end else begin
          cmd.set_pending = 1'b1;
          state_next      = S_DONE;
        end
      end
      S_DONE: begin
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
